[rtl/core/wpe_pkg.sv]
// Shared types, constants and helper functions of the WS2812 pixel encoder.
package wpe_pkg;

	localparam int MaxPixels   = 256;
	localparam int PixAw       = $clog2(MaxPixels);
	localparam int IdxW        = 8;
	localparam int ChanW       = 8;
	localparam int CntW        = 9;
	localparam int BriW        = 8;
	localparam int CfgIdxW     = 1;
	localparam int CfgDataW    = 9;
	localparam int TickW       = 4;
	localparam int BitsPerPix  = 3 * ChanW;
	localparam int BitCntW     = $clog2(BitsPerPix);
	localparam int PixW        = 3 * ChanW;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_SEND  = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS  = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_PIXEL_COUNT = 1'd1;

	localparam logic [BriW-1:0] BRIGHTNESS_RST  = 8'd255;
	localparam logic [CntW-1:0] PIXEL_COUNT_RST = 9'd256;

	localparam logic [TickW-1:0] ONE_HIGH  = 4'd8;
	localparam logic [TickW-1:0] ONE_LOW   = 4'd4;
	localparam logic [TickW-1:0] ZERO_HIGH = 4'd4;
	localparam logic [TickW-1:0] ZERO_LOW  = 4'd8;

	localparam logic [BitCntW-1:0] LAST_BIT = BitCntW'(BitsPerPix - 1);

	// Command bundle from the controller to the datapath.
	typedef struct packed {
		logic write;
		logic read;
		logic mul;
		logic load;
		logic emit;
	} wpe_cmd_t;

	// Status bundle from the datapath to the controller.
	typedef struct packed {
		logic store_hit;
		logic send_hit;
		logic out_free;
		logic last_bit;
	} wpe_sts_t;

	// Number of pixels actually in use: the configured count, capped at capacity.
	function automatic logic [CntW-1:0] count_in_use(input logic [CntW-1:0] pc);
		return (pc > CntW'(MaxPixels)) ? CntW'(MaxPixels) : pc;
	endfunction

	// Exact floor(x / 255) for any product of two bytes.
	function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
		logic [2*ChanW:0] t;
		t = {1'b0, x} + {{(ChanW+1){1'b0}}, x[2*ChanW-1:ChanW]} + 17'd1;
		return t[2*ChanW-1:ChanW];
	endfunction

endpackage

[rtl/core/ws2812_pixel_encoder.sv]
// Top level of the WS2812 pixel encoder: controller plus datapath.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    operation, pixel_index, red, green, blue
//   out       out_valid / out_ready  bit_value, high_ticks, low_ticks,
//                                    last_of_pixel, last_of_frame
//   config    cfg_write              cfg_index, cfg_data
//
// A store beat is written to the store and the block is ready again right after it.
// A send beat passes through the store read, the multiply and the divide by 255,
// and the symbol shifter then sends the pixel, one bit per cycle while the
// output does not stall.
// Reset clears the 256 per-entry valid bits at once, so the store reads as
// zero immediately; there is no clearing pass.
// An output stall holds the shifter; a new input beat is taken while the last
// symbol of a pixel still waits in the output register.
module ws2812_pixel_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [wpe_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [wpe_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [wpe_pkg::IdxW-1:0]          pixel_index,
	input  logic [wpe_pkg::ChanW-1:0]         red,
	input  logic [wpe_pkg::ChanW-1:0]         green,
	input  logic [wpe_pkg::ChanW-1:0]         blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              bit_value,
	output logic [wpe_pkg::TickW-1:0]         high_ticks,
	output logic [wpe_pkg::TickW-1:0]         low_ticks,
	output logic                              last_of_pixel,
	output logic                              last_of_frame
);
	import wpe_pkg::*;

	// Commands flow from the controller, status back from the datapath.
	wpe_cmd_t cmd;
	wpe_sts_t sts;

	wpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the pixel store and the output
	// register, so a finished symbol can wait while the shifter holds.
	wpe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.pixel_index   (pixel_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bit_value     (bit_value),
		.high_ticks    (high_ticks),
		.low_ticks     (low_ticks),
		.last_of_pixel (last_of_pixel),
		.last_of_frame (last_of_frame)
	);

endmodule

[rtl/core/wpe_ctrl.sv]
// Controller state machine of the WS2812 pixel encoder.
module wpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wpe_pkg::wpe_sts_t sts,
	output wpe_pkg::wpe_cmd_t cmd
);
	import wpe_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	always_comb begin
		cmd.write = accept & sts.store_hit;
		cmd.read  = accept & sts.send_hit;
		cmd.mul   = (state_q == ST_MUL);
		cmd.load  = (state_q == ST_DIV);
		cmd.emit  = (state_q == ST_EMIT) & sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.read) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (cmd.emit && sts.last_bit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/wpe_datapath.sv]
// Datapath of the WS2812 pixel encoder: pixel store, scaling and symbol shifter.
module wpe_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wpe_pkg::wpe_cmd_t                 cmd,
	output wpe_pkg::wpe_sts_t                 sts,
	input  logic                              cfg_write,
	input  logic [wpe_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [wpe_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                              operation,
	input  logic [wpe_pkg::IdxW-1:0]          pixel_index,
	input  logic [wpe_pkg::ChanW-1:0]         red,
	input  logic [wpe_pkg::ChanW-1:0]         green,
	input  logic [wpe_pkg::ChanW-1:0]         blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              bit_value,
	output logic [wpe_pkg::TickW-1:0]         high_ticks,
	output logic [wpe_pkg::TickW-1:0]         low_ticks,
	output logic                              last_of_pixel,
	output logic                              last_of_frame
);
	import wpe_pkg::*;

	logic [BriW-1:0]       brightness_q;
	logic [CntW-1:0]       pixel_count_q;
	logic [CntW-1:0]       count_use;
	logic                  in_use;
	logic                  last_pix_d;
	logic [PixAw-1:0]      addr;

	logic [PixW-1:0]       mem [MaxPixels];
	logic [MaxPixels-1:0]  valid_q;
	logic [PixW-1:0]       rd_data_q;
	logic                  rd_valid_q;
	logic                  last_pix_q;
	logic [PixW-1:0]       pixel;

	logic [2*ChanW-1:0]    prod_r_q;
	logic [2*ChanW-1:0]    prod_g_q;
	logic [2*ChanW-1:0]    prod_b_q;
	logic [PixW-1:0]       shift_q;
	logic [BitCntW-1:0]    bit_cnt_q;
	logic                  out_valid_q;
	logic                  bit_q;
	logic                  last_pixel_bit_q;
	logic                  last_frame_bit_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= BRIGHTNESS_RST;
			pixel_count_q <= PIXEL_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BRIGHTNESS:  brightness_q  <= cfg_data[BriW-1:0];
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data[CntW-1:0];
				default: ;
			endcase
		end
	end

	assign count_use  = count_in_use(pixel_count_q);
	assign in_use     = ({1'b0, pixel_index} < count_use);
	assign last_pix_d = (({1'b0, pixel_index} + 9'd1) == count_use);
	assign addr       = pixel_index[PixAw-1:0];

	always_comb begin
		sts.store_hit = in_use & (operation == OP_STORE);
		sts.send_hit  = in_use & (operation == OP_SEND);
		sts.out_free  = ~out_valid_q | out_ready;
		sts.last_bit  = (bit_cnt_q == LAST_BIT);
	end

	// Pixel store; an entry never written reads as zero through its valid bit.
	always_ff @(posedge clk) begin
		if (cmd.write) mem[addr] <= {red, green, blue};
		if (cmd.read) begin
			rd_data_q  <= mem[addr];
			last_pix_q <= last_pix_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.write) valid_q[addr] <= 1'b1;
			if (cmd.read)  rd_valid_q    <= valid_q[addr];
		end
	end

	assign pixel = rd_valid_q ? rd_data_q : '0;

	// Channel scaling, split into a multiply stage and a divide-by-255 stage.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_r_q <= (2*ChanW)'(pixel[3*ChanW-1:2*ChanW]) * (2*ChanW)'(brightness_q);
			prod_g_q <= (2*ChanW)'(pixel[2*ChanW-1:ChanW])   * (2*ChanW)'(brightness_q);
			prod_b_q <= (2*ChanW)'(pixel[ChanW-1:0])         * (2*ChanW)'(brightness_q);
		end
		if (cmd.load) begin
			shift_q <= {div255(prod_g_q), div255(prod_r_q), div255(prod_b_q)};
		end else if (cmd.emit) begin
			shift_q <= {shift_q[PixW-2:0], 1'b0};
		end
		if (cmd.emit) begin
			bit_q            <= shift_q[PixW-1];
			last_pixel_bit_q <= sts.last_bit;
			last_frame_bit_q <= sts.last_bit & last_pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q <= '0;
			end else if (cmd.emit) begin
				bit_cnt_q <= bit_cnt_q + 5'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign bit_value     = bit_q;
	assign high_ticks    = bit_q ? ONE_HIGH : ZERO_HIGH;
	assign low_ticks     = bit_q ? ONE_LOW : ZERO_LOW;
	assign last_of_pixel = last_pixel_bit_q;
	assign last_of_frame = last_frame_bit_q;

endmodule

[rtl/core/wpe_checker.sv]
// Port-level assertions of the WS2812 pixel encoder and their bind.
module wpe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        bit_value,
	input logic [wpe_pkg::TickW-1:0]   high_ticks,
	input logic [wpe_pkg::TickW-1:0]   low_ticks,
	input logic                        last_of_pixel,
	input logic                        last_of_frame
);
	import wpe_pkg::*;

	// A stalled symbol keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(bit_value) &&
			$stable(high_ticks) && $stable(low_ticks) &&
			$stable(last_of_pixel) && $stable(last_of_frame)))
		else $error("stalled output beat changed");

	// While a pixel is still being sent, no input beat is taken.
	a_busy_mid_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_pixel) |-> !in_ready)
		else $error("input ready in the middle of a pixel");

	// An accepted input beat needs at least the store read before any symbol.
	a_no_early_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> !out_valid)
		else $error("symbol appeared right after input accept");

	// The symbol after the last one of a pixel starts a new pixel.
	a_gap_after_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_pixel) |=> !(out_valid && last_of_pixel))
		else $error("symbol followed the last symbol of a pixel");

endmodule

bind ws2812_pixel_encoder wpe_checker u_wpe_checker (.*);
